@@ hdl/hnc_pkg.sv @@
package hnc_pkg;

  localparam logic [7:0] REPORT_INTERVAL_RESET = 8'd60;

  localparam logic [7:0] CMD_SET_OUTPUTS = 8'd20;
  localparam logic [7:0] CMD_REQ_REPORT  = 8'd50;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam logic [7:0] MODE_OFF        = 8'd0;
  localparam logic [7:0] MODE_ON         = 8'd1;
  localparam logic [7:0] MODE_THERMOSTAT = 8'd2;

  localparam logic [7:0] STATUS_OK     = 8'd0;
  localparam logic [7:0] SIGN_NEGATIVE = 8'd1;

  localparam logic [1:0] KIND_PERIODIC = 2'd0;
  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Temperature magnitude in tenths: up to 255*10 + 255.
  localparam int TEMP_W = 12;

  typedef struct packed {
    logic       req_type;
    logic [7:0] read_status;
    logic [7:0] temp_int;
    logic [7:0] temp_tenth;
    logic [7:0] temp_sign;
    logic [7:0] packet_function;
    logic [7:0] lamp_cmd;
    logic [7:0] heater_mode_cmd;
    logic [7:0] setpoint_cmd;
  } item_t;

  typedef struct packed {
    logic       heater_on;
    logic       lamp_on;
    logic       report_valid;
    logic [1:0] report_kind;
    logic [7:0] heater_mode;
    logic [7:0] setpoint;
    logic [7:0] sensor_status;
  } result_t;

  typedef struct packed {
    logic       lamp;
    logic       heater;
    logic [7:0] mode;
    logic [7:0] setpoint;
    logic [7:0] counter;
    logic       pending;
  } state_t;

endpackage

@@ hdl/hnc_item_if.sv @@
interface hnc_item_if;
  logic                valid;
  logic                ready;
  hnc_pkg::item_t      payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/hnc_result_if.sv @@
interface hnc_result_if;
  logic                valid;
  logic                ready;
  hnc_pkg::result_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/hnc_core.sv @@
module hnc_core (
  input  hnc_pkg::item_t   item_i,
  input  hnc_pkg::state_t  state_i,
  input  logic [7:0]       interval_i,
  output hnc_pkg::state_t  state_o,
  output hnc_pkg::result_t result_o
);

  logic [hnc_pkg::TEMP_W-1:0] mag;
  logic                       neg;
  logic                       too_hot;
  logic                       too_cold;
  logic [7:0]                 cnt_inc;

  // Magnitude times ten as two shifts and an add.
  assign mag = ({4'd0, item_i.temp_int} << 3) + ({4'd0, item_i.temp_int} << 1)
             + {4'd0, item_i.temp_tenth};
  assign neg = (item_i.temp_sign == hnc_pkg::SIGN_NEGATIVE) && (mag != '0);

  // The setpoint is never negative, so any negative reading is below it.
  assign too_hot  = !neg && (mag > {4'd0, state_i.setpoint});
  assign too_cold = neg || (mag < {4'd0, state_i.setpoint});
  assign cnt_inc  = state_i.counter + 8'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.report_kind = hnc_pkg::KIND_PERIODIC;

    if (item_i.req_type == hnc_pkg::REQ_COMMAND) begin
      case (item_i.packet_function)
        hnc_pkg::CMD_SET_OUTPUTS: begin
          state_o.lamp     = (item_i.lamp_cmd != 8'd0);
          state_o.mode     = item_i.heater_mode_cmd;
          state_o.setpoint = item_i.setpoint_cmd;
          if (item_i.heater_mode_cmd == hnc_pkg::MODE_OFF) begin
            state_o.heater = 1'b0;
          end else if (item_i.heater_mode_cmd == hnc_pkg::MODE_ON) begin
            state_o.heater = 1'b1;
          end
        end
        hnc_pkg::CMD_REQ_REPORT: begin
          state_o.pending = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      result_o.sensor_status = item_i.read_status;
      if (item_i.read_status == hnc_pkg::STATUS_OK) begin
        if (state_i.mode == hnc_pkg::MODE_THERMOSTAT) begin
          if (too_hot) begin
            state_o.heater = 1'b0;
          end else if (too_cold) begin
            state_o.heater = 1'b1;
          end
        end
        if (state_i.pending) begin
          state_o.pending       = 1'b0;
          state_o.counter       = 8'd0;
          result_o.report_valid = 1'b1;
          result_o.report_kind  = hnc_pkg::KIND_REQUEST;
        end else if (cnt_inc >= interval_i) begin
          state_o.counter       = 8'd0;
          result_o.report_valid = 1'b1;
        end else begin
          state_o.counter = cnt_inc;
        end
      end else begin
        result_o.report_valid = 1'b1;
        result_o.report_kind  = hnc_pkg::KIND_ERROR;
      end
    end

    result_o.heater_on   = state_o.heater;
    result_o.lamp_on     = state_o.lamp;
    result_o.heater_mode = state_o.mode;
    result_o.setpoint    = state_o.setpoint;
  end

endmodule

@@ hdl/heater_thermostat_node_controller_unit.sv @@
// Heater and lamp node controller with a deadband thermostat. Each item is a
// sensor sample or a command packet and yields exactly one result item that
// shows the lamp, heater, mode and setpoint after the update, plus any status
// report. An item is registered on entry; its result is registered in the
// output register when the item leaves the input register, and stays valid
// until it is taken. One item is taken every cycle while the result side
// keeps up; a result that is not taken holds the item behind it.
// The single update step between the input register and the state and result
// registers sets that rate. Write report_interval only while the block is
// idle.
module heater_thermostat_node_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  hnc_item_if.sink           item_i,
  hnc_result_if.source       result_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic              in_valid_q;
  hnc_pkg::item_t    in_q;
  logic              out_valid_q;
  hnc_pkg::result_t  out_q;
  hnc_pkg::state_t   state_q;
  hnc_pkg::state_t   state_d;
  hnc_pkg::result_t  result_d;
  logic [7:0]        interval_q;
  logic              advance;
  logic              fire;

  assign advance      = !out_valid_q || result_o.ready;
  assign fire         = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  hnc_core u_core (
    .item_i     (in_q),
    .state_i    (state_q),
    .interval_i (interval_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      interval_q  <= hnc_pkg::REPORT_INTERVAL_RESET;
    end else begin
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.payload;
    end
    if (fire) begin
      out_q <= result_d;
    end
  end

  // Forced modes pin the heater.
  a_mode_off_heater: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == hnc_pkg::MODE_OFF) |-> !state_q.heater)
    else $error("heater on in forced-off mode");

  a_mode_on_heater: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == hnc_pkg::MODE_ON) |-> state_q.heater)
    else $error("heater off in forced-on mode");

  // A good sample always consumes a pending report request.
  a_pending_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.req_type == hnc_pkg::REQ_SAMPLE)
          && (in_q.read_status == hnc_pkg::STATUS_OK)) |=> !state_q.pending)
    else $error("report request survived a good sample");

  // A good sample with a request pending yields a request report.
  a_request_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.req_type == hnc_pkg::REQ_SAMPLE)
          && (in_q.read_status == hnc_pkg::STATUS_OK) && state_q.pending)
      |=> (out_valid_q && out_q.report_valid
           && (out_q.report_kind == hnc_pkg::KIND_REQUEST)))
    else $error("pending request not reported");

  a_item_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("held item lost or overwritten");

endmodule
